// ----- rtl/fractional_delay_line_with_pickup_tap_defines.svh -----
// assertion macros shared by the rtl
`ifndef FRACTIONAL_DELAY_LINE_WITH_PICKUP_TAP_DEFINES_SVH
`define FRACTIONAL_DELAY_LINE_WITH_PICKUP_TAP_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define FDL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdl assertion failed");
// antecedent implies consequent in the next cycle
`define FDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdl assertion failed");
`else
`define FDL_ASSERT_IMPL(lbl, ante, cons)
`define FDL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/fdl_pkg.sv -----
`timescale 1ns / 1ps

package fdl_pkg;

    // store size is a power of two so index wrap is plain modular arithmetic
    localparam int ADDR_W          = 16;
    localparam int DEPTH           = 1 << ADDR_W;
    localparam int DELAY_FRAC_BITS = 8;
    localparam int SAMPLE_W        = 24;

    localparam int D_W       = ADDR_W + 16;
    localparam int DLY_SHIFT = 16 - DELAY_FRAC_BITS;
    localparam int DS_W      = (((24 + DLY_SHIFT) > D_W) ? (24 + DLY_SHIFT) : D_W) + 2;
    localparam int MUL_A_W   = ((D_W + 1) > 37) ? (D_W + 1) : 37;
    localparam int MUL_B_W   = 25;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 58;
    localparam int COEF_W    = 32;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    // reciprocal constants for exact floor division by 3 and by 5
    localparam logic [15:0] K3_HI    = 16'hAAAA;
    localparam logic [15:0] K3_LO    = 16'hAAAB;
    localparam int          K3_SHIFT = 33;
    localparam logic [15:0] K5_HI    = 16'hCCCC;
    localparam logic [15:0] K5_LO    = 16'hCCCD;
    localparam int          K5_SHIFT = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEEDBACK_GAIN     = 3'd0,
        REG_FEEDBACK_POSITIVE = 3'd1,
        REG_DELAY_ADJUST      = 3'd2,
        REG_PICKUP_POSITION   = 3'd3,
        REG_PICKUP_MOD_AMOUNT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] feedback_gain;
        logic               feedback_positive;
        logic signed [12:0] delay_adjust;
        logic        [16:0] pickup_position;
        logic signed [16:0] pickup_mod_amount;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pickup_cv;
        logic        [23:0]         delay_samples;
        logic signed [SAMPLE_W-1:0] feedback_sample;
        logic signed [SAMPLE_W-1:0] in_sample;
    } item_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_FB, S_WR, S_PB, S_C3, S_C2, S_C1, S_C0,
        S_D3A, S_D3B, S_D0A, S_D0B,
        S_RD0, S_RD1, S_RD2, S_RD3, S_L3, S_L4,
        S_PK, S_PK2, S_PT, S_TC, S_TD, S_TA,
        S_PR0, S_PR1, S_PR2, S_PR3, S_DONE
    } state_t;

endpackage

// ----- rtl/fdl_ram.sv -----
`timescale 1ns / 1ps

module fdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fdl_mul.sv -----
`timescale 1ns / 1ps

module fdl_mul (
    input  logic                                clk,
    input  logic signed [fdl_pkg::MUL_A_W-1:0]  a,
    input  logic signed [fdl_pkg::MUL_B_W-1:0]  b,
    output logic signed [fdl_pkg::PROD_W-1:0]   p
);
    import fdl_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    // registered signed product
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ----- rtl/fdl_core.sv -----
`timescale 1ns / 1ps

module fdl_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  fdl_pkg::item_t                      item,
    input  fdl_pkg::cfg_t                       cfg,
    input  logic                                res_ready,
    output fdl_pkg::core_stat_t                 stat,
    output logic signed [fdl_pkg::SAMPLE_W-1:0] delay_out,
    output logic signed [fdl_pkg::SAMPLE_W-1:0] pickup_out,
    output fdl_pkg::ram_req_t                   ram_req,
    input  logic [fdl_pkg::SAMPLE_W-1:0]        ram_rdata,
    output logic signed [fdl_pkg::MUL_A_W-1:0]  mul_a,
    output logic signed [fdl_pkg::MUL_B_W-1:0]  mul_b,
    input  logic signed [fdl_pkg::PROD_W-1:0]   mul_p
);
    import fdl_pkg::*;

    localparam logic [16:0] ONE     = 17'd65536;
    localparam logic [17:0] TWO     = 18'd131072;
    localparam logic signed [DS_W-1:0] D_LO = DS_W'(3 * 65536);
    localparam logic signed [DS_W-1:0] D_HI = DS_W'((longint'(DEPTH) - 4) * 65536);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]         wi_reg;
    item_t                     item_reg;
    logic [D_W-1:0]            d_reg;
    logic [32:0]               a_reg;
    logic [33:0]               b_reg;
    logic [31:0]               n3_reg;
    logic [31:0]               n0_reg;
    logic [47:0]               p1_reg;
    logic signed [COEF_W-1:0]  c0_reg, c1_reg, c2_reg, c3_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] pk_reg;
    logic [21:0]               qn_reg;
    logic                      qneg_reg;
    logic [16:0]               t_reg;
    logic [D_W-1:0]            ptap_reg;

    // delay in Q16, clamped
    logic signed [DS_W-1:0] ds;
    logic signed [DS_W-1:0] d_clamp;
    assign ds = (DS_W'($signed({1'b0, item_reg.delay_samples})) <<< DLY_SHIFT)
              - (DS_W'(cfg.delay_adjust) <<< 8);
    assign d_clamp = (ds < D_LO) ? D_LO : ((ds > D_HI) ? D_HI : ds);

    // lagrange fraction and base address
    logic [15:0] df;
    logic [16:0] u, u_p1, one_mu;
    logic [17:0] two_mu;
    logic [ADDR_W-1:0] lag_addr0;
    assign df     = d_reg[15:0];
    assign u      = (df != 16'd0) ? (ONE - 17'(df)) : 17'd0;
    assign u_p1   = u + ONE;
    assign one_mu = ONE - u;
    assign two_mu = TWO - 18'(u);
    assign lag_addr0 = wi_reg - (d_reg[D_W-1:16] + ADDR_W'(df != 16'd0) + ADDR_W'(1));

    // pickup fraction and base address
    logic [15:0] pf;
    logic [16:0] u2, one_mu2;
    logic [ADDR_W-1:0] pk_addr0;
    assign pf      = ptap_reg[15:0];
    assign u2      = (pf != 16'd0) ? (ONE - 17'(pf)) : 17'd0;
    assign one_mu2 = (pf != 16'd0) ? 17'(pf) : ONE;
    assign pk_addr0 = wi_reg - (ptap_reg[D_W-1:16] + ADDR_W'(pf != 16'd0));

    // written sample: input plus or minus rounded feedback, saturated
    logic signed [24:0] term;
    logic signed [25:0] x_full;
    logic [SAMPLE_W-1:0] x_sat;
    assign term   = 25'((mul_p + PROD_W'(32768)) >>> 16);
    assign x_full = cfg.feedback_positive ? (26'(item_reg.in_sample) + 26'(term))
                                          : (26'(item_reg.in_sample) - 26'(term));
    assign x_sat  = (x_full > 26'sd8388607)  ? 24'h7FFFFF :
                    (x_full < -26'sd8388608) ? 24'h800000 : x_full[23:0];

    // quotient from two partial products of a reciprocal multiply
    logic [65:0] dsum;
    logic [31:0] q3, q5;
    assign dsum = {2'b00, p1_reg, 16'h0000} + 66'(mul_p[47:0]);
    assign q3   = 32'(dsum >> K3_SHIFT);
    assign q5   = 32'(dsum >> K5_SHIFT);

    logic signed [PROD_W-1:0] qabs;
    assign qabs = (mul_p < 0) ? -mul_p : mul_p;

    logic signed [20:0] t_full;
    assign t_full = 21'($signed({1'b0, cfg.pickup_position}))
                  + (qneg_reg ? -21'($signed({1'b0, q5[19:0]}))
                              : 21'($signed({1'b0, q5[19:0]})));

    logic signed [ACC_W-1:0] y_round;
    assign y_round = (acc_reg + ACC_W'(64'sd536870912)) >>> 30;

    logic signed [ACC_W-1:0] pk_sum;
    assign pk_sum = (acc_reg + ACC_W'(mul_p) + ACC_W'(32768)) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && res_ready)
            begin
                wi_reg <= wi_reg + ADDR_W'(1);
            end
        end
    end

    // datapath captures per step
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            S_IDLE: if (start) item_reg <= item;
            S_FB:   d_reg  <= D_W'(d_clamp);
            S_PB:   a_reg  <= mul_p[32:0];
            S_C3:   b_reg  <= mul_p[33:0];
            S_C2:   n3_reg <= mul_p[50:19];
            S_C1:   c2_reg <= $signed(mul_p[50:19]);
            S_C0:   c1_reg <= $signed(mul_p[50:19]);
            S_D3A:  n0_reg <= mul_p[50:19];
            S_D3B:  p1_reg <= mul_p[47:0];
            S_D0A:  c3_reg <= -$signed(q3);
            S_D0B:  p1_reg <= mul_p[47:0];
            S_RD0:  c0_reg <= -$signed(q3);
            S_RD2:  acc_reg <= ACC_W'(mul_p);
            S_RD3, S_L3, S_L4: acc_reg <= acc_reg + ACC_W'(mul_p);
            S_PK:
            begin
                y_reg    <= (y_round > ACC_W'(5242880))  ? 24'sd5242880 :
                            (y_round < -ACC_W'(5242880)) ? -24'sd5242880 : y_round[23:0];
                qneg_reg <= (mul_p < 0);
                qn_reg   <= qabs[39:18];
            end
            S_PT:   p1_reg <= mul_p[47:0];
            S_TC:   t_reg  <= (t_full < 0) ? 17'd0 :
                              (t_full > 21'sd65536) ? ONE : t_full[16:0];
            S_TA:   ptap_reg <= D_W'((mul_p + PROD_W'(32768)) >>> 16);
            S_PR2:  acc_reg <= ACC_W'(mul_p);
            S_PR3:  pk_reg  <= pk_sum[23:0];
            default: ;
        endcase
    end

    // sequencer: next step, multiplier operands and store port
    always_comb
    begin
        state_next    = state_reg;
        mul_a         = '0;
        mul_b         = '0;
        ram_req.we    = 1'b0;
        ram_req.addr  = lag_addr0;
        ram_req.wdata = x_sat;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_FB;
            S_FB:
            begin
                mul_a = MUL_A_W'(item_reg.feedback_sample);
                mul_b = MUL_B_W'($signed({1'b0, cfg.feedback_gain}));
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_req.we   = 1'b1;
                ram_req.addr = wi_reg;
                mul_a = MUL_A_W'($signed({1'b0, u_p1}));
                mul_b = MUL_B_W'($signed({1'b0, u}));
                state_next = S_PB;
            end
            S_PB:
            begin
                mul_a = MUL_A_W'($signed({1'b0, one_mu}));
                mul_b = MUL_B_W'($signed({1'b0, two_mu}));
                state_next = S_C3;
            end
            S_C3:
            begin
                mul_a = MUL_A_W'($signed({1'b0, a_reg}));
                mul_b = MUL_B_W'($signed({1'b0, one_mu}));
                state_next = S_C2;
            end
            S_C2:
            begin
                mul_a = MUL_A_W'($signed({1'b0, a_reg}));
                mul_b = MUL_B_W'($signed({1'b0, two_mu}));
                state_next = S_C1;
            end
            S_C1:
            begin
                mul_a = MUL_A_W'($signed({1'b0, b_reg}));
                mul_b = MUL_B_W'($signed({1'b0, u_p1}));
                state_next = S_C0;
            end
            S_C0:
            begin
                mul_a = MUL_A_W'($signed({1'b0, b_reg}));
                mul_b = MUL_B_W'($signed({1'b0, u}));
                state_next = S_D3A;
            end
            S_D3A:
            begin
                mul_a = MUL_A_W'($signed({1'b0, n3_reg}));
                mul_b = MUL_B_W'($signed({1'b0, K3_HI}));
                state_next = S_D3B;
            end
            S_D3B:
            begin
                mul_a = MUL_A_W'($signed({1'b0, n3_reg}));
                mul_b = MUL_B_W'($signed({1'b0, K3_LO}));
                state_next = S_D0A;
            end
            S_D0A:
            begin
                mul_a = MUL_A_W'($signed({1'b0, n0_reg}));
                mul_b = MUL_B_W'($signed({1'b0, K3_HI}));
                state_next = S_D0B;
            end
            S_D0B:
            begin
                mul_a = MUL_A_W'($signed({1'b0, n0_reg}));
                mul_b = MUL_B_W'($signed({1'b0, K3_LO}));
                state_next = S_RD0;
            end
            S_RD0:
            begin
                ram_req.addr = lag_addr0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ram_req.addr = lag_addr0 + ADDR_W'(1);
                mul_a = MUL_A_W'(c0_reg);
                mul_b = MUL_B_W'($signed(ram_rdata));
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ram_req.addr = lag_addr0 + ADDR_W'(2);
                mul_a = MUL_A_W'(c1_reg);
                mul_b = MUL_B_W'($signed(ram_rdata));
                state_next = S_RD3;
            end
            S_RD3:
            begin
                ram_req.addr = lag_addr0 + ADDR_W'(3);
                mul_a = MUL_A_W'(c2_reg);
                mul_b = MUL_B_W'($signed(ram_rdata));
                state_next = S_L3;
            end
            S_L3:
            begin
                mul_a = MUL_A_W'(c3_reg);
                mul_b = MUL_B_W'($signed(ram_rdata));
                state_next = S_L4;
            end
            S_L4:
            begin
                mul_a = MUL_A_W'(item_reg.pickup_cv);
                mul_b = MUL_B_W'(cfg.pickup_mod_amount);
                state_next = S_PK;
            end
            S_PK:  state_next = S_PK2;
            S_PK2:
            begin
                mul_a = MUL_A_W'($signed({1'b0, qn_reg}));
                mul_b = MUL_B_W'($signed({1'b0, K5_HI}));
                state_next = S_PT;
            end
            S_PT:
            begin
                mul_a = MUL_A_W'($signed({1'b0, qn_reg}));
                mul_b = MUL_B_W'($signed({1'b0, K5_LO}));
                state_next = S_TC;
            end
            S_TC:  state_next = S_TD;
            S_TD:
            begin
                mul_a = MUL_A_W'($signed({1'b0, d_reg}));
                mul_b = MUL_B_W'($signed({1'b0, t_reg}));
                state_next = S_TA;
            end
            S_TA:  state_next = S_PR0;
            S_PR0:
            begin
                ram_req.addr = pk_addr0;
                state_next = S_PR1;
            end
            S_PR1:
            begin
                ram_req.addr = pk_addr0 + ADDR_W'(1);
                mul_a = MUL_A_W'($signed({1'b0, one_mu2}));
                mul_b = MUL_B_W'($signed(ram_rdata));
                state_next = S_PR2;
            end
            S_PR2:
            begin
                mul_a = MUL_A_W'($signed({1'b0, u2}));
                mul_b = MUL_B_W'($signed(ram_rdata));
                state_next = S_PR3;
            end
            S_PR3: state_next = S_DONE;
            S_DONE: if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.done  = (state_reg == S_DONE);
    assign delay_out  = y_reg;
    assign pickup_out = pk_reg;

endmodule

// ----- rtl/fractional_delay_line_with_pickup_tap.sv -----
`timescale 1ns / 1ps
// channel  direction  handshake                 payload
// s_*      in         s_tvalid / s_tready       in, feedback, delay, pickup cv
// m_*      out        m_tvalid / m_tready       delay_out, pickup_out
// cfg_*    in         cfg_wen (no wait)         register index, write data
//
// a word runs 28 sequencer steps from its accept until it shows on m_tvalid; the
// next word is taken only once the sequencer is back in idle, paced by
// the single multiplier (21 products per word) and the one store port (1 write, 6 reads)
// after reset a clearing pass zeroes all 65536 store entries, with s_tready low
// the result sits in an output register, so a stalled m_tready only holds the
// sequencer in its last step until the register frees up

`include "fractional_delay_line_with_pickup_tap_defines.svh"

module fractional_delay_line_with_pickup_tap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // in_sample[23:0], feedback_sample[47:24], delay_samples[71:48], pickup_cv[95:72]
    input  logic [95:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // delay_out[23:0], pickup_out[47:24]
    output logic [47:0]                     m_tdata,
    input  logic                            cfg_wen,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdl_pkg::CFG_W-1:0]       cfg_wdata
);
    import fdl_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feedback_gain     <= '0;
            cfg_reg.feedback_positive <= 1'b0;
            cfg_reg.delay_adjust      <= '0;
            cfg_reg.pickup_position   <= 17'd32768;
            cfg_reg.pickup_mod_amount <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_FEEDBACK_GAIN:     cfg_reg.feedback_gain     <= cfg_wdata[15:0];
                REG_FEEDBACK_POSITIVE: cfg_reg.feedback_positive <= cfg_wdata[0];
                REG_DELAY_ADJUST:      cfg_reg.delay_adjust      <= $signed(cfg_wdata[12:0]);
                REG_PICKUP_POSITION:   cfg_reg.pickup_position   <= cfg_wdata[16:0];
                REG_PICKUP_MOD_AMOUNT: cfg_reg.pickup_mod_amount <= $signed(cfg_wdata[16:0]);
                default: ;
            endcase
        end
    end

    // store clearing pass after reset, one entry per cycle
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // core and its shared resources
    core_stat_t              core_stat;
    ram_req_t                core_req;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SAMPLE_W-1:0] delay_out, pickup_out;
    logic                    start;
    logic                    res_ready;
    item_t                   item;

    assign s_tready = core_stat.idle && !clearing_reg;
    assign start    = s_tvalid && s_tready;
    assign item     = item_t'(s_tdata);

    // output register parts the core from the downstream stall
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (core_stat.done && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_stat.done && res_ready)
        begin
            m_tdata_reg <= {pickup_out, delay_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // store port: clearing pass owns it until done
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;

    assign ram_we    = clearing_reg ? 1'b1 : core_req.we;
    assign ram_addr  = clearing_reg ? clr_addr_reg : core_req.addr;
    assign ram_wdata = clearing_reg ? '0 : core_req.wdata;

    fdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fdl_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fdl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .cfg        (cfg_reg),
        .res_ready  (res_ready),
        .stat       (core_stat),
        .delay_out  (delay_out),
        .pickup_out (pickup_out),
        .ram_req    (core_req),
        .ram_rdata  (ram_rdata),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .mul_p      (mul_p)
    );

    // core never writes the store while the clearing pass runs
    `FDL_ASSERT_IMPL(a_no_write_in_clear, clearing_reg, !core_req.we)
    // a started word leaves the core busy
    `FDL_ASSERT_NEXT(a_start_busy, start, !core_stat.idle)
    // a finished word waits for the output register
    `FDL_ASSERT_NEXT(a_done_holds, core_stat.done && !res_ready, core_stat.done)
    // delivered delay sample stays within the clamp range
    `FDL_ASSERT_IMPL(a_out_clamped, m_tvalid_reg,
        ($signed(m_tdata_reg[23:0]) <= 24'sd5242880) &&
        ($signed(m_tdata_reg[23:0]) >= -24'sd5242880))

endmodule

// ----- verif/tb_fractional_delay_line_with_pickup_tap.sv -----
`timescale 1ns / 1ps

module tb_fractional_delay_line_with_pickup_tap;

    import fdl_pkg::*;

    localparam longint ONE          = 65536;
    localparam longint CYCLE_LIMIT  = 3000000;
    localparam int     SETTLE       = 60;
    localparam int     RANDOM_WORDS = 1930;
    // indexes past the last register, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    // predicts delay and pickup words from its own copy of store and registers
    class delay_scoreboard;
        logic signed [23:0] store [DEPTH];
        longint             wr_index;
        longint             gain;
        longint             fb_add;
        longint             trim;
        longint             pick_pos;
        longint             pick_mod;
        logic [47:0]        pending [$];
        int                 errors;
        int                 checked;

        function new();
            foreach (store[i]) store[i] = '0;
            wr_index = 0;
            gain     = 0;
            fb_add   = 0;
            trim     = 0;
            pick_pos = 32768;
            pick_mod = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FEEDBACK_GAIN:     gain     = longint'(val[15:0]);
                REG_FEEDBACK_POSITIVE: fb_add   = longint'(val[0]);
                REG_DELAY_ADJUST:      trim     = longint'($signed(val[12:0]));
                REG_PICKUP_POSITION:   pick_pos = longint'(val[16:0]);
                REG_PICKUP_MOD_AMOUNT: pick_mod = longint'($signed(val[16:0]));
                default: ;
            endcase
        endfunction

        function longint tap(longint back, longint fwd);
            longint idx;
            idx = (wr_index + DEPTH - (back % DEPTH) + fwd) % DEPTH;
            return longint'(store[idx]);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_word(logic [95:0] w);
            longint xin, fb, dly, cv, term, x, d, di, df, u, b;
            longint c0, c1, c2, c3, acc, y, t, p, pi, pf, s0, s1, pk;
            xin = longint'($signed(w[23:0]));
            fb  = longint'($signed(w[47:24]));
            dly = longint'(w[71:48]);
            cv  = longint'($signed(w[95:72]));
            // feedback into the write sample, saturated
            term = (gain * fb + 32768) >>> 16;
            x = fb_add != 0 ? xin + term : xin - term;
            x = clip(x, -8388608, 8388607);
            store[wr_index] = x[23:0];
            // delay in q16, short and long limits
            d  = dly * (64'sd1 << (16 - DELAY_FRAC_BITS)) - trim * 256;
            d  = clip(d, 3 * ONE, (DEPTH - 4) * ONE);
            di = d >> 16;
            df = d & 65535;
            u  = df != 0 ? ONE - df : 0;
            b  = di + (df != 0 ? 1 : 0) + 1;
            c3 = ((u + ONE) * u * (u - ONE)) / 1572864;
            c2 = -(((u + ONE) * u * (u - 2 * ONE)) / 524288);
            c1 = ((u + ONE) * (u - ONE) * (u - 2 * ONE)) / 524288;
            c0 = -((u * (u - ONE) * (u - 2 * ONE)) / 1572864);
            acc = c0 * tap(b, 0) + c1 * tap(b, 1) + c2 * tap(b, 2) + c3 * tap(b, 3);
            y = (acc + (64'sd1 << 29)) >>> 30;
            y = clip(y, -5242880, 5242880);
            // pickup tap between write and read point
            t  = pick_pos + (pick_mod * cv) / 1310720;
            t  = clip(t, 0, ONE);
            p  = (t * d + 32768) >> 16;
            pi = p >> 16;
            pf = p & 65535;
            u  = pf != 0 ? ONE - pf : 0;
            b  = pi + (pf != 0 ? 1 : 0);
            s0 = tap(b, 0);
            s1 = tap(b, 1);
            pk = ((ONE - u) * s0 + u * s1 + 32768) >>> 16;
            pending.push_back({pk[23:0], y[23:0]});
            wr_index = (wr_index + 1) % DEPTH;
        endfunction

        function void check_word(logic [47:0] got);
            logic [47:0] want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %h", $time, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want[23:0] !== got[23:0])
            begin
                errors++;
                $display("%0t: delay_out expected %0d actual %0d", $time,
                         $signed(want[23:0]), $signed(got[23:0]));
            end
            if (want[47:24] !== got[47:24])
            begin
                errors++;
                $display("%0t: pickup_out expected %0d actual %0d", $time,
                         $signed(want[47:24]), $signed(got[47:24]));
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // in_sample[23:0], feedback_sample[47:24], delay_samples[71:48], pickup_cv[95:72]
    logic [95:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // delay_out[23:0], pickup_out[47:24]
    logic [47:0]          m_tdata;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    delay_scoreboard sb;
    longint          cycles = 0;
    bit              calm;      // no idling on either side while set
    int              phases;

    fractional_delay_line_with_pickup_tap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run guard, the clearing pass after reset is included in the limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_fractional_delay_line_with_pickup_tap: errors");
            $finish;
        end
    end

    // one register write, only called while the block is idle
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    // offer one word after a random gap and hold it until accepted
    task automatic send_word(logic [95:0] w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(w);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [95:0] pack_word(logic [23:0] xin, logic [23:0] fb,
                                              logic [23:0] dly, logic [23:0] cv);
        return {cv, dly, fb, xin};
    endfunction

    // mostly delays that reach recently written samples, a few anywhere
    function automatic logic [95:0] random_word();
        logic [23:0] dly;
        case ($urandom_range(0, 9))
            0:       dly = 24'($urandom);
            1:       dly = 24'($urandom_range(0, 1023));
            default: dly = 24'($urandom_range(0, 24'h3FFFF));
        endcase
        return pack_word(24'($urandom), 24'($urandom), dly, 24'($urandom));
    endfunction

    task automatic random_regs();
        set_reg(REG_FEEDBACK_GAIN, CFG_W'($urandom));
        set_reg(REG_FEEDBACK_POSITIVE, CFG_W'($urandom));
        set_reg(REG_DELAY_ADJUST, $urandom_range(0, 1) ? CFG_W'($urandom)
                                                       : CFG_W'(-$urandom_range(0, 4096)));
        set_reg(REG_PICKUP_POSITION, $urandom_range(0, 3) == 0 ? CFG_W'($urandom)
                                                               : CFG_W'($urandom_range(0, 65536)));
        set_reg(REG_PICKUP_MOD_AMOUNT, CFG_W'($urandom));
        set_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), CFG_W'($urandom));
    endtask

    // result side: random stall per word, checks on each accepted word
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_word(m_tdata);
        end
    end

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        phases    = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_index = REG_FEEDBACK_GAIN;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, zero fraction
        send_word(pack_word(24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'h7FFFFF));
        send_word(pack_word(24'h800000, 24'h800000, 24'hFFFFFF, 24'h800000));
        send_word(pack_word(24'h123456, 24'h000000, 24'd768, 24'd0));
        send_word(pack_word(24'h400000, 24'h000000, 24'd1000, 24'd0));
        drain();

        // max gain, adding: feedback overflow, short delay from positive trim
        set_reg(REG_FEEDBACK_GAIN, 17'hFFFF);
        set_reg(REG_FEEDBACK_POSITIVE, 17'd1);
        set_reg(REG_DELAY_ADJUST, 17'h0FFF);
        set_reg(REG_PICKUP_POSITION, 17'd65536);
        set_reg(REG_PICKUP_MOD_AMOUNT, 17'h08000);
        set_reg(REG_SPARE_FIRST, 17'h1FFFF);
        send_word(pack_word(24'h7FFFFF, 24'h7FFFFF, 24'd900, 24'h7FFFFF));
        send_word(pack_word(24'h700000, 24'h7FFFFF, 24'd1, 24'h800000));
        send_word(pack_word(24'h800000, 24'h800000, 24'd1280, 24'h3FFFFF));
        send_word(pack_word(24'h7FFFFF, 24'h7FFFFF, 24'd3, 24'h000001));
        drain();

        // subtracting, longest trim, out-of-range position, negative depth
        set_reg(REG_FEEDBACK_POSITIVE, 17'd0);
        set_reg(REG_DELAY_ADJUST, 17'h1F000);
        set_reg(REG_PICKUP_POSITION, 17'h1FFFF);
        set_reg(REG_PICKUP_MOD_AMOUNT, 17'h18000);
        set_reg(REG_SPARE_LAST, 17'h00000);
        send_word(pack_word(24'h7FFFFF, 24'h800000, 24'd0, 24'h7FFFFF));
        send_word(pack_word(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h800000));
        send_word(pack_word(24'h555555, 24'h2AAAAA, 24'd16128, 24'h123456));
        drain();

        // pickup fraction zero and output clamp from large samples
        set_reg(REG_FEEDBACK_GAIN, 17'd65470);
        set_reg(REG_DELAY_ADJUST, 17'd0);
        set_reg(REG_PICKUP_POSITION, 17'd0);
        set_reg(REG_PICKUP_MOD_AMOUNT, 17'h1FFFF);
        repeat (6) send_word(pack_word(24'h7FFFFF, 24'h000000, 24'd896, 24'h7FFFFF));
        send_word(pack_word(24'h800000, 24'h000000, 24'd933, 24'h800000));
        send_word(pack_word(24'h7FFFFF, 24'h000000, 24'd1100, 24'hFFFFFF));
        drain();

        // random phases; the sender holds off for all results between them
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
            begin
                drain();
                random_regs();
                calm = (phases % 4 == 3);
                phases++;
            end
            send_word(random_word());
        end
        drain();

        $display("covered %0d words checked over %0d random register settings",
                 sb.checked, phases);
        $display("extremes of gain, trim, pickup position and depth, both signs of feedback");
        if (sb.errors == 0)
        begin
            $display("tb_fractional_delay_line_with_pickup_tap: clean");
        end
        else
        begin
            $display("tb_fractional_delay_line_with_pickup_tap: errors");
        end
        $finish;
    end

endmodule
